[sv/blde_pkg.sv]
package blde_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int OP_W    = 3;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 3;
	localparam int TOTAL_W = 7;

	localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
	localparam logic [OP_W-1:0] OP_DEL_FIRST  = 3'd1;
	localparam logic [OP_W-1:0] OP_DEL_LAST   = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_AFTER  = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_BEFORE = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_OUT   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOKEY   = 3'd2;
	localparam logic [STAT_W-1:0] ST_NONEIGH = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

endpackage

[sv/blde_if.sv]
interface blde_in_if;
	logic                                  valid;
	logic                                  ready;
	logic        [blde_pkg::OP_W-1:0]      op;
	logic signed [blde_pkg::DATA_W-1:0]    value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface blde_out_if;
	logic                                  valid;
	logic                                  ready;
	logic        [blde_pkg::STAT_W-1:0]    status;
	logic signed [blde_pkg::DATA_W-1:0]    data_out;
	logic                                  last;
	logic        [blde_pkg::TOTAL_W-1:0]   entry_total;

	modport source (output valid, output status, output data_out, output last,
		output entry_total, input ready);
	modport sink (input valid, input status, input data_out, input last,
		input entry_total, output ready);
endinterface

[sv/bounded_list_delete_engine_top.sv]
// Append, delete last and unused op codes: result word loaded in the result state; the
// next request is taken only once the engine is back in idle. Delete first: a shift;
// delete after/before key: a search through the single memory read port, then a shift.
// Read out: one word per cycle while the output register is free, then back to idle.
// Reset clears the entry count and control state; the value memory is not
// cleared and needs no clearing pass.
module bounded_list_delete_engine_top #(
	parameter int CAPACITY = blde_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	blde_in_if.sink           req,
	blde_out_if.source        rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = blde_pkg::DATA_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_DUMP   = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0]                     state_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  idx_q;
	logic [blde_pkg::OP_W-1:0]      op_q;
	logic [DW-1:0]                  key_q;
	logic [blde_pkg::STAT_W-1:0]    res_q;
	logic                           rv_s1;
	logic [AW-1:0]                  addr_s1;

	logic                           out_valid_q;
	logic [blde_pkg::STAT_W-1:0]    out_status_q;
	logic [DW-1:0]                  out_data_q;
	logic                           out_last_q;
	logic [blde_pkg::TOTAL_W-1:0]   out_total_q;

	logic                           accept;
	logic                           slot_free;
	logic                           hit;
	logic                           emit;
	logic                           rd_issue;
	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [DW-1:0]                  mem_wdata;
	logic [DW-1:0]                  mem_rdata;
	logic                           out_load;
	logic [blde_pkg::STAT_W-1:0]    out_status_d;
	logic [DW-1:0]                  out_data_d;
	logic                           out_last_d;
	logic                           is_full;
	logic                           is_empty;
	logic [AW-1:0]                  last_addr;

	blde_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign hit       = rv_s1 && (mem_rdata == key_q);
	assign is_full   = (count_q >= CW'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign last_addr = AW'(count_q - CW'(1));
	assign emit      = (state_q == S_DUMP) && rv_s1 && slot_free;

	always_comb begin
		rd_issue     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = count_q[AW-1:0];
		mem_wdata    = req.value;
		out_load     = 1'b0;
		out_status_d = res_q;
		out_data_d   = '0;
		out_last_d   = 1'b1;
		case (state_q)
			S_IDLE: begin
				mem_we = accept && (req.op == blde_pkg::OP_APPEND) && !is_full;
			end
			S_SEARCH: begin
				rd_issue = (idx_q < count_q) && !hit;
			end
			S_SHIFT: begin
				rd_issue  = (idx_q < count_q);
				mem_we    = rv_s1;
				mem_waddr = addr_s1 - AW'(1);
				mem_wdata = mem_rdata;
			end
			S_DUMP: begin
				rd_issue     = (idx_q < count_q) && (!rv_s1 || emit);
				out_load     = emit;
				out_status_d = blde_pkg::ST_OK;
				out_data_d   = mem_rdata;
				out_last_d   = (addr_s1 == last_addr);
			end
			S_RESULT: begin
				out_load = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			if (rd_issue) begin
				idx_q   <= idx_q + CW'(1);
				addr_s1 <= idx_q[AW-1:0];
			end
			case (state_q)
				S_IDLE: begin
					rv_s1 <= 1'b0;
					if (accept) begin
						op_q  <= req.op;
						key_q <= req.value;
						res_q <= blde_pkg::ST_OK;
						idx_q <= '0;
						state_q <= S_RESULT;
						case (req.op)
							blde_pkg::OP_APPEND: begin
								if (is_full) begin
									res_q <= blde_pkg::ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							blde_pkg::OP_DEL_FIRST: begin
								if (is_empty) begin
									res_q <= blde_pkg::ST_EMPTY;
								end else begin
									idx_q   <= CW'(1);
									state_q <= S_SHIFT;
								end
							end
							blde_pkg::OP_DEL_LAST: begin
								if (is_empty) begin
									res_q <= blde_pkg::ST_EMPTY;
								end else begin
									count_q <= count_q - CW'(1);
								end
							end
							blde_pkg::OP_DEL_AFTER, blde_pkg::OP_DEL_BEFORE: begin
								if (is_empty) begin
									res_q <= blde_pkg::ST_EMPTY;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							blde_pkg::OP_READ_OUT: begin
								if (is_empty) begin
									res_q <= blde_pkg::ST_EMPTY;
								end else begin
									state_q <= S_DUMP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					rv_s1 <= rd_issue;
					if (hit) begin
						rv_s1 <= 1'b0;
						if (op_q == blde_pkg::OP_DEL_AFTER) begin
							if (CW'(addr_s1) + CW'(1) >= count_q) begin
								res_q   <= blde_pkg::ST_NONEIGH;
								state_q <= S_RESULT;
							end else begin
								idx_q   <= CW'(addr_s1) + CW'(2);
								state_q <= S_SHIFT;
							end
						end else begin
							if (addr_s1 == '0) begin
								res_q   <= blde_pkg::ST_NONEIGH;
								state_q <= S_RESULT;
							end else begin
								idx_q   <= CW'(addr_s1);
								state_q <= S_SHIFT;
							end
						end
					end else if (!rv_s1 && !rd_issue) begin
						res_q   <= blde_pkg::ST_NOKEY;
						state_q <= S_RESULT;
					end
				end
				S_SHIFT: begin
					rv_s1 <= rd_issue;
					if (!rd_issue && !rv_s1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESULT;
					end
				end
				S_DUMP: begin
					rv_s1 <= rd_issue || (rv_s1 && !emit);
					if (emit && out_last_d) begin
						state_q <= S_IDLE;
					end
				end
				S_RESULT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_data_q   <= out_data_d;
			out_last_q   <= out_last_d;
			out_total_q  <= blde_pkg::TOTAL_W'(count_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.data_out    = out_data_q;
	assign rsp.last        = out_last_q;
	assign rsp.entry_total = out_total_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CW'(1)) || (count_q + CW'(1) == $past(count_q)))
		else $error("entry count moved by more than one");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CW'(mem_waddr) <= count_q)
		else $error("store written beyond the list end");

	a_dump_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> !mem_we)
		else $error("store written during read out");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_last_d |=> state_q == S_IDLE)
		else $error("final word loaded but engine not idle");
`endif

endmodule

[sv/blde_ram.sv]
module blde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[tb/sv/list_check_pkg.sv]
package list_check_pkg;
	import blde_pkg::*;

	typedef struct {
		logic        [STAT_W-1:0]  status;
		logic signed [DATA_W-1:0]  data_out;
		logic                      last;
		logic        [TOTAL_W-1:0] entry_total;
	} list_word_t;

	class list_scoreboard;
		int                       capacity;
		logic signed [DATA_W-1:0] entries[$];
		list_word_t               due_words[$];
		int                       failures;
		int                       words_checked;
		int                       requests_seen;
		int                       full_hits;
		int                       empty_hits;
		int                       peak_length;

		function new(int cap);
			capacity      = cap;
			failures      = 0;
			words_checked = 0;
			requests_seen = 0;
			full_hits     = 0;
			empty_hits    = 0;
			peak_length   = 0;
		endfunction

		function int find_first(logic signed [DATA_W-1:0] key);
			foreach (entries[i]) begin
				if (entries[i] == key)
					return i;
			end
			return -1;
		endfunction

		function void push_word(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] d, logic lst);
			list_word_t w;
			w.status      = st;
			w.data_out    = d;
			w.last        = lst;
			w.entry_total = TOTAL_W'(entries.size());
			due_words.push_back(w);
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
			int                pos;
			logic [STAT_W-1:0] st;
			st = ST_OK;
			requests_seen++;
			case (op)
				OP_APPEND: begin
					if (entries.size() >= capacity)
						st = ST_FULL;
					else
						entries.push_back(value);
				end
				OP_DEL_FIRST: begin
					if (entries.size() == 0)
						st = ST_EMPTY;
					else
						void'(entries.pop_front());
				end
				OP_DEL_LAST: begin
					if (entries.size() == 0)
						st = ST_EMPTY;
					else
						void'(entries.pop_back());
				end
				OP_DEL_AFTER: begin
					pos = find_first(value);
					if (entries.size() == 0)
						st = ST_EMPTY;
					else if (pos < 0)
						st = ST_NOKEY;
					else if (pos == entries.size() - 1)
						st = ST_NONEIGH;
					else
						entries.delete(pos + 1);
				end
				OP_DEL_BEFORE: begin
					pos = find_first(value);
					if (entries.size() == 0)
						st = ST_EMPTY;
					else if (pos < 0)
						st = ST_NOKEY;
					else if (pos == 0)
						st = ST_NONEIGH;
					else
						entries.delete(pos - 1);
				end
				OP_READ_OUT: begin
					if (entries.size() == 0) begin
						empty_hits++;
						push_word(ST_EMPTY, '0, 1'b1);
					end else begin
						for (int i = 0; i < entries.size(); i++)
							push_word(ST_OK, entries[i], i == entries.size() - 1);
					end
					return;
				end
				default: ;
			endcase
			if (st == ST_FULL)
				full_hits++;
			if (st == ST_EMPTY)
				empty_hits++;
			if (entries.size() > peak_length)
				peak_length = entries.size();
			push_word(st, '0, 1'b1);
		endfunction

		function void check_result(list_word_t got);
			list_word_t exp;
			if (due_words.size() == 0) begin
				$error("result word with no request pending (status %0d data %0d)",
					got.status, got.data_out);
				failures++;
				return;
			end
			exp = due_words.pop_front();
			words_checked++;
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				failures++;
			end
			if (got.data_out !== exp.data_out) begin
				$error("data_out: expected %0d, got %0d", exp.data_out, got.data_out);
				failures++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0d, got %0d", exp.last, got.last);
				failures++;
			end
			if (got.entry_total !== exp.entry_total) begin
				$error("entry_total: expected %0d, got %0d", exp.entry_total, got.entry_total);
				failures++;
			end
		endfunction

		function int pending();
			return due_words.size();
		endfunction
	endclass

endpackage

[tb/sv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import blde_pkg::*;
	import list_check_pkg::*;

	localparam int               CAP            = CAPACITY_DEF;
	localparam int               RANDOM_ITEMS   = 255;
	localparam int               WATCHDOG_LIMIT = 4000;
	localparam int               DRAIN_CYCLES   = 150;
	localparam logic [OP_W-1:0]  OP_SPARE_A     = 3'd6;
	localparam logic [OP_W-1:0]  OP_SPARE_B     = 3'd7;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	bit   steady;
	int   quiet_cycles;

	list_scoreboard sb;

	blde_in_if  req_if();
	blde_out_if rsp_if();

	bounded_list_delete_engine_top #(.CAPACITY(CAP)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.op    = OP_APPEND;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
	end

	always @(negedge clk) begin
		rsp_if.ready = steady || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin
		list_word_t w;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			w.status      = rsp_if.status;
			w.data_out    = rsp_if.data_out;
			w.last        = rsp_if.last;
			w.entry_total = rsp_if.entry_total;
			sb.check_result(w);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$error("no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic send_word(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 27) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.op    = op;
		req_if.value = value;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(op, value);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return int'($urandom_range(6)) - 3;
		if (r < 35) begin
			case ($urandom_range(3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (sb.entries.size() == 0 || r < 20)
			return $urandom;
		if (r < 35)
			return sb.entries[sb.entries.size() - 1];
		if (r < 50)
			return sb.entries[0];
		return sb.entries[$urandom_range(sb.entries.size() - 1)];
	endfunction

	task automatic random_phase();
		int n;
		int append_pct;
		int s;
		n = 0;
		while (n < RANDOM_ITEMS) begin
			append_pct = (n < 100) ? 88 : (n < 180) ? 45 : 20;
			steady     = (n >= 120 && n < 160);
			if ($urandom_range(99) < append_pct) begin
				send_word(OP_APPEND, pick_value());
				n++;
			end else begin
				s = $urandom_range(99);
				if (s < 20)
					send_word(OP_DEL_FIRST, pick_value());
				else if (s < 40)
					send_word(OP_DEL_LAST, pick_value());
				else if (s < 62)
					send_word(OP_DEL_AFTER, pick_key());
				else if (s < 84)
					send_word(OP_DEL_BEFORE, pick_key());
				else if (s < 97)
					send_word(OP_READ_OUT, pick_value());
				else
					send_word($urandom_range(1) ? OP_SPARE_B : OP_SPARE_A, pick_value());
				if (s < 97)
					n++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		sb     = new(CAP);
		steady = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list on every delete and read op, spare codes
		send_word(OP_READ_OUT, '0);
		send_word(OP_DEL_FIRST, '0);
		send_word(OP_DEL_LAST, '0);
		send_word(OP_DEL_AFTER, 32'sd5);
		send_word(OP_DEL_BEFORE, 32'sd5);
		send_word(OP_SPARE_A, VAL_MAX);
		send_word(OP_SPARE_B, VAL_MIN);
		// extremes and duplicate keys
		send_word(OP_APPEND, VAL_MIN);
		send_word(OP_APPEND, VAL_MAX);
		send_word(OP_APPEND, '0);
		send_word(OP_APPEND, -1);
		send_word(OP_APPEND, VAL_MAX);
		send_word(OP_READ_OUT, '0);
		send_word(OP_DEL_AFTER, 32'sd12345);
		send_word(OP_DEL_BEFORE, 32'sd12345);
		send_word(OP_DEL_AFTER, VAL_MAX);
		send_word(OP_DEL_BEFORE, VAL_MIN);
		send_word(OP_DEL_BEFORE, VAL_MAX);
		send_word(OP_DEL_AFTER, VAL_MAX);
		send_word(OP_DEL_AFTER, VAL_MAX);
		send_word(OP_DEL_BEFORE, VAL_MAX);
		send_word(OP_APPEND, 32'sd7);
		send_word(OP_DEL_FIRST, '0);
		send_word(OP_DEL_LAST, '0);
		send_word(OP_READ_OUT, '0);

		random_phase();

		@(negedge clk);
		req_if.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			$error("%0d expected result words never arrived", sb.pending());
			sb.failures++;
		end
		$display("Ran %0d requests and checked %0d result words; longest list %0d of %0d.",
			sb.requests_seen, sb.words_checked, sb.peak_length, CAP);
		$display("Full-list appends: %0d, ops on an empty list: %0d.",
			sb.full_hits, sb.empty_hits);
		if (sb.failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
